// File: rtl/core/pie_pkg.sv
// Shared types and constants for the postfix integer evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pie_pkg;

    // default operand stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // token kind
    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_APPLY = 1'b1
    } act_t;

    // operator codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    // classified token as it travels through the queue
    typedef struct packed {
        act_t  action;
        word_t value;
        op_t   opcode;
        logic  last;
    } cmd_t;

    // divider request
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/postfix_integer_evaluator.sv
// Postfix expression evaluator on a bounded 32-bit operand stack. Each input
// transfer carries one token: an operand is pushed, an operator pops b then a
// and pushes a op b (add, subtract, multiply wrap modulo 2^32; divide truncates
// toward zero). The first error of an expression (underflow, overflow, divide
// by zero) is kept as a sticky status. The token marked last produces one
// result transfer with the top of stack (0 if empty) and the status, and the
// stack is cleared for the next expression. Tokens pass through an input
// register and a two-entry queue to the execution side, which takes a push or an
// underflowing operator in its idle state. Add, subtract, multiply and a divide
// by zero go through an execute state (after the registered stack memory read),
// and any other divide then waits in a divide state for the bit-serial divider.
// A last token passes through an emit state to load the result register, and
// waits there while an earlier result transfer is still waiting. The
// stack holds STACK_DEPTH entries: the top sits in a register and the rest in
// a single-port-write memory; it needs no clearing pass after reset.
// Depends on pie_pkg, pie_front, pie_queue, pie_div and pie_back.
`default_nettype none

module postfix_integer_evaluator #(
    parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic signed [31:0]  s_operand_value,
    input  wire logic [1:0]          s_operator_code,
    input  wire logic                s_last_token,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_result_value,
    output logic [2:0]               m_status
);
    import pie_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    // token intake and classification
    pie_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_operand_value (s_operand_value),
        .s_operator_code (s_operator_code),
        .s_last_token    (s_last_token),
        .cmd_valid       (fq_valid),
        .cmd_ready       (fq_ready),
        .cmd             (fq_cmd)
    );

    // decoupling queue
    pie_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    // stack machine and result register
    pie_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (qb_valid),
        .cmd_ready      (qb_ready),
        .cmd            (qb_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

endmodule

`default_nettype wire

// File: rtl/core/pie_front.sv
// Input stage: takes token transfers and classifies them into commands.
// Depends on pie_pkg; feeds pie_queue.
`default_nettype none

module pie_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic signed [31:0]  s_operand_value,
    input  wire logic [1:0]          s_operator_code,
    input  wire logic                s_last_token,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output pie_pkg::cmd_t            cmd
);
    import pie_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    // accept whenever the holding register is empty or draining
    assign s_ready = !valid_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    // classify the token
    always_comb begin
        cmd_next.action = act_t'(s_action);
        cmd_next.value  = (s_action == ACT_PUSH) ? word_t'($unsigned(s_operand_value)) : '0;
        cmd_next.opcode = op_t'(s_operator_code);
        cmd_next.last   = s_last_token;
        if (take) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// File: rtl/core/pie_queue.sv
// Short command queue between the front and the back of the evaluator.
// Depends on pie_pkg for the command type and queue depth.
`default_nettype none

module pie_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire pie_pkg::cmd_t  wr_cmd,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output pie_pkg::cmd_t       rd_cmd
);
    import pie_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wptr_reg;
    logic [QAW-1:0] rptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           do_wr;
    logic           do_rd;

    assign wr_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_cmd   = entry_reg[rptr_reg];

    // occupancy update
    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + QCW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - QCW'(1);
        end
    end

    // pointers and storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wptr_reg <= (wptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QAW'(1);
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QAW'(1);
            end
        end
        if (do_wr) begin
            entry_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pie_div.sv
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on pie_pkg for the request and response types.
`default_nettype none

module pie_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pie_pkg::div_req_t  req,
    output pie_pkg::div_rsp_t       rsp
);
    import pie_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    word_t         rem_reg;
    word_t         quo_reg;
    word_t         dvs_reg;
    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;
    logic          fits;
    logic          final_step;

    // one restoring step
    assign shifted    = {rem_reg, quo_reg[WORD_W-1]};
    assign diff       = shifted - {1'b0, dvs_reg};
    assign fits       = !diff[WORD_W];
    assign final_step = busy_reg && (cnt_reg == CW'(WORD_W - 1));

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= final_step;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (final_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/pie_back.sv
// Execution side: operand stack, arithmetic, status tracking and result register.
// Depends on pie_pkg; uses pie_div for the divide operator.
`default_nettype none

module pie_back #(
    parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire pie_pkg::cmd_t       cmd,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_result_value,
    output logic [2:0]               m_status
);
    import pie_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    // entries below the top of stack live in memory
    word_t          stack_mem [STACK_DEPTH];
    word_t          rd_data_reg;
    logic [AW-1:0]  mem_raddr;
    logic [AW-1:0]  mem_waddr;
    logic           mem_we;

    bk_state_t      state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    status_t        err_reg, err_next;
    word_t          tos_reg, tos_next;
    op_t            op_reg, op_next;
    logic           last_reg, last_next;
    logic           neg_reg, neg_next;
    logic           out_valid_reg, out_valid_next;
    word_t          out_value_reg, out_value_next;
    status_t        out_status_reg, out_status_next;

    div_req_t       div_req;
    div_rsp_t       div_rsp;

    word_t          opa;
    word_t          opb;
    word_t          mag_a;
    word_t          mag_b;
    logic [2*WORD_W-1:0] product;
    logic           out_free;

    assign opa     = rd_data_reg;
    assign opb     = tos_reg;
    assign mag_a   = opa[WORD_W-1] ? word_t'(-opa) : opa;
    assign mag_b   = opb[WORD_W-1] ? word_t'(-opb) : opb;
    assign product = opa * opb;
    assign out_free = !out_valid_reg || m_ready;

    pie_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer: next state and datapath control
    always_comb begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        cmd_ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = AW'(sp_reg - SPW'(1));
        mem_raddr       = AW'(sp_reg - SPW'(2));
        div_req.start    = 1'b0;
        div_req.dividend = mag_a;
        div_req.divisor  = mag_b;

        case (state_reg)
            BK_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    op_next   = cmd.opcode;
                    last_next = cmd.last;
                    state_next = cmd.last ? BK_EMIT : BK_IDLE;
                    if (cmd.action == ACT_PUSH) begin
                        if (sp_reg < SPW'(STACK_DEPTH)) begin
                            // spill old top of stack, new value becomes top
                            mem_we   = (sp_reg != '0);
                            tos_next = cmd.value;
                            sp_next  = sp_reg + SPW'(1);
                        end else if (err_reg == ST_OK) begin
                            err_next = ST_OVERFLOW;
                        end
                    end else if (sp_reg < SPW'(2)) begin
                        if (err_reg == ST_OK) begin
                            err_next = ST_UNDERFLOW;
                        end
                    end else begin
                        // second operand is read from memory this cycle
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_EXEC: begin
                state_next = last_reg ? BK_EMIT : BK_IDLE;
                case (op_reg)
                    OP_ADD: begin
                        tos_next = opa + opb;
                        sp_next  = sp_reg - SPW'(1);
                    end
                    OP_SUB: begin
                        tos_next = opa - opb;
                        sp_next  = sp_reg - SPW'(1);
                    end
                    OP_MUL: begin
                        tos_next = product[WORD_W-1:0];
                        sp_next  = sp_reg - SPW'(1);
                    end
                    OP_DIV: begin
                        if (opb == '0) begin
                            // divide by zero pops both and leaves zero
                            tos_next = '0;
                            sp_next  = sp_reg - SPW'(1);
                            if (err_reg == ST_OK) begin
                                err_next = ST_DIVZERO;
                            end
                        end else begin
                            div_req.start = 1'b1;
                            neg_next      = opa[WORD_W-1] ^ opb[WORD_W-1];
                            state_next    = BK_DIV;
                        end
                    end
                    default: begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_DIV: begin
                if (div_rsp.done) begin
                    tos_next   = neg_reg ? word_t'(-div_rsp.quotient) : div_rsp.quotient;
                    sp_next    = sp_reg - SPW'(1);
                    state_next = last_reg ? BK_EMIT : BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (sp_reg == '0) begin
                        out_value_next  = '0;
                        out_status_next = (err_reg != ST_OK) ? err_reg : ST_EMPTY;
                    end else begin
                        out_value_next  = tos_reg;
                        out_status_next = err_reg;
                    end
                    sp_next    = '0;
                    err_next   = ST_OK;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // stack memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = $signed(out_value_reg);
    assign m_status       = out_status_reg;

endmodule

`default_nettype wire
